@@ sv/lwd_pkg.sv @@
// ----------------------------------------------------------------------------
// lwd_pkg
// Shared types and constants of the LZSS window decompressor: window geometry,
// result status codes, the decode action code and controller/datapath buses.
// ----------------------------------------------------------------------------
package lwd_pkg;

   // Ring window geometry
   localparam int WIN_ADDR_W = 12;
   localparam int WIN_DEPTH  = 4096;
   localparam int MAX_MATCH  = 18;
   localparam int MATCH_BIAS = 2;
   localparam logic [WIN_ADDR_W-1:0] START_POS = WIN_ADDR_W'(WIN_DEPTH - MAX_MATCH);
   localparam logic [7:0] BLANK_BYTE = 8'h20;

   // Fill count saturates at the window depth
   localparam int FILL_W = WIN_ADDR_W + 1;
   localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(WIN_DEPTH);

   // Bytes still to copy for one match (up to MAX_MATCH)
   localparam int COPY_W = 5;

   // Configuration port
   localparam int CSR_ADDR_W = 3;
   localparam logic IDX_EXPECTED_LENGTH = 1'b0;

   // Result status codes
   localparam logic [1:0] ST_DATA     = 2'd0;
   localparam logic [1:0] ST_SUM_OK   = 2'd1;
   localparam logic [1:0] ST_SUM_BAD  = 2'd2;
   localparam logic [1:0] ST_OVERRUN  = 2'd3;

   // What an accepted input byte leads to
   typedef enum logic [2:0] {
      ACT_NONE,
      ACT_LITERAL,
      ACT_MATCH,
      ACT_OVERRUN,
      ACT_VERDICT
   } action_type;

   // Controller to datapath
   typedef struct packed {
      logic accept;    // input transaction this cycle
      logic read;      // issue window read for the next copy byte
      logic deliver;   // result transaction this cycle
   } ctl_cmd_type;

   // Datapath to controller
   typedef struct packed {
      action_type action;     // decode of the byte on the input port
      logic       copy_more;  // presented copy byte is not the last of its match
   } ctl_status_type;

endpackage

@@ sv/lzss_window_decompressor_top.sv @@
// ----------------------------------------------------------------------------
// lzss_window_decompressor_top
// LZSS decoder over a 4 KiB ring window with a running byte sum and a
// trailing little-endian checksum check.
// ----------------------------------------------------------------------------
//  channel | ports                              | moves
//  --------+------------------------------------+-------------------------------
//  req     | req_valid/req_ready, req_in_byte   | one compressed byte
//  rsp     | rsp_valid/rsp_ready, rsp_out_byte, | one decoded byte or verdict
//          | rsp_status, rsp_last               |
//  csr     | csr_psel ... csr_pready            | expected_length at offset 0
//
//  One transaction at a time: an input byte is accepted while idle; a literal
//  or a status result is then held in the result register, and a match copies
//  each byte by a window read and then a present, as the single window port
//  is read and then written for each byte. A flag, offset or early checksum
//  byte gives no result. Output stalls hold the result and block input.
//  Reset is synchronous; no clearing pass, unwritten window bytes read as space.
// ----------------------------------------------------------------------------
module lzss_window_decompressor_top (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [7:0]                      req_in_byte,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic [7:0]                      rsp_out_byte,
   output logic [1:0]                      rsp_status,
   output logic                            rsp_last,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [lwd_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  logic [31:0]                     csr_pwdata,
   output logic [31:0]                     csr_prdata,
   output logic                            csr_pready
);

   lwd_pkg::ctl_cmd_type    cmd;
   lwd_pkg::ctl_status_type sts;
   logic                    cfg_write;
   logic [31:0]             expected_length;

   // Register access
   assign csr_pready = 1'b1;
   assign cfg_write  = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == lwd_pkg::IDX_EXPECTED_LENGTH);
   assign csr_prdata = (csr_paddr[2] == lwd_pkg::IDX_EXPECTED_LENGTH) ?
                       expected_length : 32'd0;

   lwd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   lwd_datapath u_datapath (
      .clock           (clock),
      .reset           (reset),
      .cmd             (cmd),
      .sts             (sts),
      .req_in_byte     (req_in_byte),
      .rsp_out_byte    (rsp_out_byte),
      .rsp_status      (rsp_status),
      .rsp_last        (rsp_last),
      .cfg_write       (cfg_write),
      .cfg_wdata       (csr_pwdata),
      .expected_length (expected_length)
   );

   // Input and result sides never overlap
   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input ready while a result is pending");

   // Status results end their input transaction
   a_status_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != lwd_pkg::ST_DATA)) |-> rsp_last)
      else $error("status result not marked last");

   // Status results carry a zero byte
   a_status_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (rsp_status != lwd_pkg::ST_DATA)) |-> (rsp_out_byte == 8'd0))
      else $error("status result with nonzero byte");

   // A copy byte that is not last is followed by another window read
   a_copy_next: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !rsp_last) |=> (!rsp_valid && !req_ready))
      else $error("match copy did not continue");

endmodule

@@ sv/lwd_ctrl.sv @@
// ----------------------------------------------------------------------------
// lwd_ctrl
// Sequencer of the decompressor: takes an input byte, steps window reads for
// match copies and holds each result until it is taken.
// ----------------------------------------------------------------------------
module lwd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   input  lwd_pkg::ctl_status_type sts,
   output lwd_pkg::ctl_cmd_type    cmd
);

   typedef enum logic [2:0] {
      S_IDLE = 3'b001,
      S_READ = 3'b010,
      S_OUT  = 3'b100
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_OUT);
   assign cmd       = '{accept:  req_valid & req_ready,
                        read:    (state_ff == S_READ),
                        deliver: rsp_valid & rsp_ready};

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               case (sts.action)
                  lwd_pkg::ACT_NONE:  state_in = S_IDLE;
                  lwd_pkg::ACT_MATCH: state_in = S_READ;
                  default:            state_in = S_OUT;
               endcase
            end
         end
         S_READ: state_in = S_OUT;
         S_OUT: begin
            if (rsp_ready) begin
               state_in = sts.copy_more ? S_READ : S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

@@ sv/lwd_datapath.sv @@
// ----------------------------------------------------------------------------
// lwd_datapath
// Token decode, ring window memory with fill count, match copy pointer,
// running and received checksums and the result register.
// ----------------------------------------------------------------------------
module lwd_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lwd_pkg::ctl_cmd_type     cmd,
   output lwd_pkg::ctl_status_type  sts,
   input  logic [7:0]              req_in_byte,
   output logic [7:0]              rsp_out_byte,
   output logic [1:0]              rsp_status,
   output logic                    rsp_last,
   input  logic                    cfg_write,
   input  logic [31:0]             cfg_wdata,
   output logic [31:0]             expected_length
);

   localparam int AW = lwd_pkg::WIN_ADDR_W;

   typedef enum logic [3:0] {
      PH_TOKEN = 4'b0001,
      PH_FIRST = 4'b0010,
      PH_HIGH  = 4'b0100,
      PH_CKS   = 4'b1000
   } phase_type;

   // Stream state
   phase_type                   phase_ff;
   logic [8:0]                  flag_shift_ff;
   logic [7:0]                  offset_low_ff;
   logic [1:0]                  cks_idx_ff;
   logic [31:0]                 remaining_ff;
   logic [31:0]                 running_sum_ff;
   logic [31:0]                 received_sum_ff;
   logic [31:0]                 expected_ff;
   logic                        halted_ff;
   logic [AW-1:0]               write_pos_ff;
   logic [lwd_pkg::FILL_W-1:0]  written_count_ff;

   // Copy and result state
   logic [AW-1:0]               rp_ff;
   logic [lwd_pkg::COPY_W-1:0]  copy_left_ff;
   logic                        copy_ff;
   logic                        data_ff;
   logic [7:0]                  out_reg_ff;
   logic [1:0]                  status_ff;
   logic [7:0]                  mem_q_ff;
   logic                        blank_ff;

   logic [7:0]                  window [lwd_pkg::WIN_DEPTH];

   // Decode signals
   logic [8:0]                  eff_flag;
   logic                        flag_load;
   logic [lwd_pkg::COPY_W-1:0]  match_count;
   logic [AW-1:0]               match_start;
   logic [31:0]                 received_next;
   logic [AW-1:0]               rp_age;
   logic                        put_byte;
   logic                        token_end;

   assign expected_length = expected_ff;

   // Flag handling: a fresh flag byte is needed once only the marker is left
   always_comb begin
      eff_flag  = flag_shift_ff;
      flag_load = 1'b0;
      if (phase_ff == PH_TOKEN) begin
         if (flag_shift_ff[8:2] == 7'd0) begin
            flag_load = 1'b1;
         end else begin
            eff_flag = {1'b0, flag_shift_ff[8:1]};
         end
      end
   end

   assign match_count   = {1'b0, req_in_byte[3:0]} + lwd_pkg::COPY_W'(lwd_pkg::MATCH_BIAS + 1);
   assign match_start   = write_pos_ff - {req_in_byte[7:4], offset_low_ff};
   assign received_next = received_sum_ff | ({24'd0, req_in_byte} << {cks_idx_ff, 3'b000});

   // Action for the byte on the input port, copy continuation
   always_comb begin
      sts.action    = lwd_pkg::ACT_NONE;
      sts.copy_more = copy_ff && (copy_left_ff != lwd_pkg::COPY_W'(1));
      if (!halted_ff) begin
         unique case (phase_ff) inside
            PH_TOKEN, PH_FIRST: begin
               if (!flag_load && eff_flag[0]) begin
                  sts.action = lwd_pkg::ACT_LITERAL;
               end
            end
            PH_HIGH: begin
               sts.action = ({27'd0, match_count} > remaining_ff) ?
                            lwd_pkg::ACT_OVERRUN : lwd_pkg::ACT_MATCH;
            end
            default: begin
               if (cks_idx_ff == 2'd3) begin
                  sts.action = lwd_pkg::ACT_VERDICT;
               end
            end
         endcase
      end
   end

   // Result port
   assign rsp_out_byte = copy_ff ? (blank_ff ? lwd_pkg::BLANK_BYTE : mem_q_ff) : out_reg_ff;
   assign rsp_status   = status_ff;
   assign rsp_last     = !sts.copy_more;

   // A data byte goes into the window when it is handed over
   assign put_byte  = cmd.deliver && data_ff;
   assign token_end = !copy_ff || (copy_left_ff == lwd_pkg::COPY_W'(1));
   assign rp_age    = rp_ff - lwd_pkg::START_POS;

   // Window memory: write on delivery, registered read for copies
   always_ff @(posedge clock) begin
      if (put_byte) begin
         window[write_pos_ff] <= rsp_out_byte;
      end
      if (cmd.read) begin
         mem_q_ff <= window[rp_ff];
         blank_ff <= ({1'b0, rp_age} >= written_count_ff);
      end
   end

   // Result payload
   always_ff @(posedge clock) begin
      if (cmd.accept && !halted_ff) begin
         case (sts.action)
            lwd_pkg::ACT_LITERAL: begin
               out_reg_ff <= req_in_byte;
               status_ff  <= lwd_pkg::ST_DATA;
            end
            lwd_pkg::ACT_MATCH: begin
               status_ff <= lwd_pkg::ST_DATA;
            end
            lwd_pkg::ACT_OVERRUN: begin
               out_reg_ff <= 8'd0;
               status_ff  <= lwd_pkg::ST_OVERRUN;
            end
            lwd_pkg::ACT_VERDICT: begin
               out_reg_ff <= 8'd0;
               status_ff  <= (received_next == running_sum_ff) ?
                             lwd_pkg::ST_SUM_OK : lwd_pkg::ST_SUM_BAD;
            end
            default: ;
         endcase
      end
   end

   // Stream and copy control state
   always_ff @(posedge clock) begin
      if (reset) begin
         expected_ff      <= 32'd1;
         halted_ff        <= 1'b0;
         phase_ff         <= PH_TOKEN;
         flag_shift_ff    <= 9'd0;
         offset_low_ff    <= 8'd0;
         cks_idx_ff       <= 2'd0;
         remaining_ff     <= 32'd1;
         running_sum_ff   <= 32'd0;
         received_sum_ff  <= 32'd0;
         write_pos_ff     <= lwd_pkg::START_POS;
         written_count_ff <= '0;
         rp_ff            <= '0;
         copy_left_ff     <= '0;
         copy_ff          <= 1'b0;
         data_ff          <= 1'b0;
      end else if (cfg_write) begin
         // New length restarts the stream
         expected_ff      <= cfg_wdata;
         phase_ff         <= (cfg_wdata == 32'd0) ? PH_CKS : PH_TOKEN;
         flag_shift_ff    <= 9'd0;
         offset_low_ff    <= 8'd0;
         cks_idx_ff       <= 2'd0;
         remaining_ff     <= cfg_wdata;
         running_sum_ff   <= 32'd0;
         received_sum_ff  <= 32'd0;
         write_pos_ff     <= lwd_pkg::START_POS;
         written_count_ff <= '0;
      end else begin
         // Input transaction
         if (cmd.accept && !halted_ff) begin
            unique case (phase_ff) inside
               PH_TOKEN, PH_FIRST: begin
                  if (flag_load) begin
                     flag_shift_ff <= {1'b1, req_in_byte};
                     phase_ff      <= PH_FIRST;
                  end else begin
                     flag_shift_ff <= eff_flag;
                     if (eff_flag[0]) begin
                        phase_ff <= PH_FIRST;
                        copy_ff  <= 1'b0;
                        data_ff  <= 1'b1;
                     end else begin
                        offset_low_ff <= req_in_byte;
                        phase_ff      <= PH_HIGH;
                     end
                  end
               end
               PH_HIGH: begin
                  if (sts.action == lwd_pkg::ACT_OVERRUN) begin
                     halted_ff <= 1'b1;
                     copy_ff   <= 1'b0;
                     data_ff   <= 1'b0;
                  end else begin
                     rp_ff        <= match_start;
                     copy_left_ff <= match_count;
                     copy_ff      <= 1'b1;
                     data_ff      <= 1'b1;
                  end
               end
               default: begin
                  if (cks_idx_ff == 2'd3) begin
                     // Verdict out, stream restarts
                     copy_ff          <= 1'b0;
                     data_ff          <= 1'b0;
                     phase_ff         <= (expected_ff == 32'd0) ? PH_CKS : PH_TOKEN;
                     flag_shift_ff    <= 9'd0;
                     offset_low_ff    <= 8'd0;
                     cks_idx_ff       <= 2'd0;
                     remaining_ff     <= expected_ff;
                     running_sum_ff   <= 32'd0;
                     received_sum_ff  <= 32'd0;
                     write_pos_ff     <= lwd_pkg::START_POS;
                     written_count_ff <= '0;
                  end else begin
                     received_sum_ff <= received_next;
                     cks_idx_ff      <= cks_idx_ff + 2'd1;
                  end
               end
            endcase
         end

         // Data byte handed over: account for it
         if (put_byte) begin
            write_pos_ff   <= write_pos_ff + AW'(1);
            running_sum_ff <= running_sum_ff + {24'd0, rsp_out_byte};
            remaining_ff   <= remaining_ff - 32'd1;
            if (written_count_ff != lwd_pkg::FILL_FULL) begin
               written_count_ff <= written_count_ff + lwd_pkg::FILL_W'(1);
            end
            if (copy_ff) begin
               copy_left_ff <= copy_left_ff - lwd_pkg::COPY_W'(1);
               rp_ff        <= rp_ff + AW'(1);
            end
            if (token_end) begin
               phase_ff   <= (remaining_ff == 32'd1) ? PH_CKS : PH_TOKEN;
               cks_idx_ff <= 2'd0;
            end
         end
      end
   end

endmodule

@@ tb/tb.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the LZSS window decompressor. A behavioral decoder
// runs beside the block and predicts every decoded byte and checksum verdict.
// Well-formed compressed streams with random content are fed through a
// valid/ready channel with random gaps and output stalls. The length register
// is written over the APB-style port between streams.
// ----------------------------------------------------------------------------
module tb;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int DRAIN_CYCLES = 50;
   localparam int RANDOM_BYTES = 160;
   localparam logic [lwd_pkg::CSR_ADDR_W-1:0] ADDR_EXPECTED_LENGTH =
      lwd_pkg::CSR_ADDR_W'(4 * lwd_pkg::IDX_EXPECTED_LENGTH);

   // Decoder phases of the behavioral model
   typedef enum logic [2:0] {
      PH_TOKEN, PH_FIRST, PH_HIGH, PH_SUM0, PH_SUM1, PH_SUM2, PH_SUM3
   } decode_phase_type;

   typedef struct packed {
      logic [7:0] data;
      logic [1:0] status;
      logic       last;
   } out_item_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [7:0]  req_in_byte = 8'h00;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [7:0]  rsp_out_byte;
   logic [1:0]  rsp_status;
   logic        rsp_last;
   logic        csr_psel = 1'b0;
   logic        csr_penable = 1'b0;
   logic        csr_pwrite = 1'b0;
   logic [lwd_pkg::CSR_ADDR_W-1:0] csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   lzss_window_decompressor_top dut (.*);

   always #5 clock = ~clock;

   // Behavioral decoder state
   logic [7:0]       win_mem [0:lwd_pkg::WIN_DEPTH-1];
   logic [11:0]      wr_pos;
   logic [12:0]      fill_count;
   logic [8:0]       flag_bits;
   decode_phase_type phase;
   logic [7:0]       off_low;
   logic [31:0]      left_bytes;
   logic [31:0]      sum_out;
   logic [31:0]      sum_in;
   logic             halted;
   logic [31:0]      cfg_length;

   out_item_type pending_out [$];

   int fail_count = 0;
   int sent_count = 0;
   int cycles = 0;
   int n_data = 0, n_ok = 0, n_bad = 0, n_overrun = 0;
   bit no_idle = 1'b0;
   int ready_left = 0;

   // ------------------------------------------------------------------------
   // Behavioral decoder
   // ------------------------------------------------------------------------
   task automatic restart_decoder();
      wr_pos = lwd_pkg::START_POS;
      fill_count = '0;
      flag_bits = '0;
      off_low = '0;
      left_bytes = cfg_length;
      sum_out = '0;
      sum_in = '0;
      phase = (left_bytes == 0) ? PH_SUM0 : PH_TOKEN;
   endtask

   task automatic reset_decoder();
      cfg_length = 32'd1;
      halted = 1'b0;
      restart_decoder();
   endtask

   function automatic logic [7:0] window_fetch(logic [11:0] p);
      logic [11:0] age;
      age = p - lwd_pkg::START_POS;
      if ({1'b0, age} < fill_count)
         return win_mem[p];
      return lwd_pkg::BLANK_BYTE;
   endfunction

   task automatic commit_byte(logic [7:0] b);
      win_mem[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
      if (fill_count < lwd_pkg::FILL_FULL)
         fill_count = fill_count + 13'd1;
      sum_out = sum_out + {24'b0, b};
      left_bytes = left_bytes - 32'd1;
   endtask

   task automatic push_out(logic [7:0] data, logic [1:0] status);
      out_item_type it;
      it.data = data;
      it.status = status;
      it.last = 1'b0;
      pending_out = {pending_out, it};
   endtask

   // Works out the results that one accepted compressed byte causes
   task automatic decode_byte(logic [7:0] b);
      logic [8:0]  shifted;
      logic [11:0] rp;
      logic [4:0]  cnt;
      logic [7:0]  c;
      int          n;
      int          idx;
      n = 0;
      if (halted)
         return;
      if (phase == PH_TOKEN) begin
         shifted = flag_bits >> 1;
         if ((shifted >> 1) == 0) begin
            // new flag byte with marker above it
            flag_bits = {1'b1, b};
            phase = PH_FIRST;
            return;
         end
         flag_bits = shifted;
         phase = PH_FIRST;
      end
      case (phase)
         PH_FIRST: begin
            if (flag_bits[0]) begin
               push_out(b, lwd_pkg::ST_DATA);
               n++;
               commit_byte(b);
               phase = (left_bytes == 0) ? PH_SUM0 : PH_TOKEN;
            end else begin
               off_low = b;
               phase = PH_HIGH;
            end
         end
         PH_HIGH: begin
            cnt = {1'b0, b[3:0]} + 5'(lwd_pkg::MATCH_BIAS + 1);
            rp = wr_pos - {b[7:4], off_low};
            if ({27'b0, cnt} > left_bytes) begin
               push_out(8'h00, lwd_pkg::ST_OVERRUN);
               n++;
               halted = 1'b1;
            end else begin
               // byte-by-byte copy, so overlapping matches repeat new bytes
               for (int i = 0; i < cnt; i++) begin
                  c = window_fetch(rp);
                  push_out(c, lwd_pkg::ST_DATA);
                  n++;
                  commit_byte(c);
                  rp = rp + 12'd1;
               end
               phase = (left_bytes == 0) ? PH_SUM0 : PH_TOKEN;
            end
         end
         default: begin
            idx = int'(phase) - int'(PH_SUM0);
            sum_in = sum_in | ({24'b0, b} << (8 * idx));
            if (idx == 3) begin
               push_out(8'h00, (sum_in == sum_out) ? lwd_pkg::ST_SUM_OK
                                                   : lwd_pkg::ST_SUM_BAD);
               n++;
               restart_decoder();
            end else begin
               phase = decode_phase_type'(phase + 3'd1);
            end
         end
      endcase
      if (n > 0)
         pending_out[pending_out.size() - 1].last = 1'b1;
   endtask

   // ------------------------------------------------------------------------
   // Cycle limit
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("Timeout after %0d cycles, %0d results outstanding",
                  cycles, pending_out.size());
         $display("== FAIL ==");
         $finish;
      end
   end

   // ------------------------------------------------------------------------
   // Output stalls: mostly short, a few long
   // ------------------------------------------------------------------------
   always @(negedge clock) begin
      if (no_idle) begin
         rsp_ready <= 1'b1;
         ready_left <= 0;
      end else if (ready_left == 0) begin
         if ($urandom_range(0, 99) < 65) begin
            rsp_ready <= 1'b1;
            ready_left <= $urandom_range(1, 12);
         end else begin
            rsp_ready <= 1'b0;
            ready_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(10, 30)
                                                       : $urandom_range(1, 3);
         end
      end else begin
         ready_left <= ready_left - 1;
      end
   end

   // ------------------------------------------------------------------------
   // Result checker: each result transaction against the oldest expectation
   // ------------------------------------------------------------------------
   always @(posedge clock) begin
      out_item_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_out.size() == 0) begin
            $error("unexpected result: out_byte %0h status %0d last %0b",
                   rsp_out_byte, rsp_status, rsp_last);
            fail_count++;
         end else begin
            want = pending_out.pop_front();
            if (rsp_out_byte !== want.data) begin
               $error("out_byte: expected %0h, got %0h", want.data, rsp_out_byte);
               fail_count++;
            end
            if (rsp_status !== want.status) begin
               $error("status: expected %0d, got %0d", want.status, rsp_status);
               fail_count++;
            end
            if (rsp_last !== want.last) begin
               $error("last: expected %0b, got %0b", want.last, rsp_last);
               fail_count++;
            end
            case (want.status)
               lwd_pkg::ST_DATA:    n_data++;
               lwd_pkg::ST_SUM_OK:  n_ok++;
               lwd_pkg::ST_SUM_BAD: n_bad++;
               default:             n_overrun++;
            endcase
         end
      end
   end

   // ------------------------------------------------------------------------
   // Shared drivers
   // ------------------------------------------------------------------------
   function automatic int gap_len();
      int r;
      if (no_idle)
         return 0;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 0;
      if (r < 92)
         return $urandom_range(1, 3);
      return $urandom_range(10, 30);
   endfunction

   // One compressed byte transaction; the decoder model runs on acceptance
   task automatic send_byte(logic [7:0] b);
      int gap;
      gap = gap_len();
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_in_byte <= b;
      do @(posedge clock); while (!req_ready);
      decode_byte(b);
      sent_count++;
   endtask

   // Drop valid, wait for all expected results, then let the block settle
   task automatic wait_idle();
      @(negedge clock);
      req_valid <= 1'b0;
      while (pending_out.size() != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   // Write expected_length and read it back
   task automatic set_length(logic [31:0] value);
      wait_idle();
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b1;
      csr_paddr <= ADDR_EXPECTED_LENGTH;
      csr_pwdata <= value;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      cfg_length = value;
      restart_decoder();
      @(negedge clock);
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      @(negedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      if (csr_prdata !== value) begin
         $error("expected_length readback: expected %0h, got %0h", value, csr_prdata);
         fail_count++;
      end
      @(negedge clock);
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   // Four little-endian checksum bytes, optionally with one bit flipped
   task automatic send_sum(bit corrupt);
      logic [31:0] word;
      word = sum_out;
      if (corrupt)
         word = word ^ (32'd1 << $urandom_range(0, 31));
      for (int i = 0; i < 4; i++)
         send_byte(word[8*i +: 8]);
   endtask

   function automatic logic [11:0] pick_offset();
      int r;
      r = $urandom_range(0, 99);
      if (r < 60)
         return 12'($urandom_range(1, 24));
      if (r < 85)
         return 12'($urandom_range(1, 400));
      return 12'($urandom_range(0, 4095));
   endfunction

   // A well-formed stream of random tokens; stops early after abort_groups
   // flag groups when that is nonzero, leaving the stream unfinished
   task automatic run_stream(logic [31:0] len, int lit_pct, int abort_groups);
      logic [31:0] left;
      logic [7:0]  flags;
      logic [7:0]  tok_lo [8];
      logic [7:0]  tok_hi [8];
      logic [11:0] off;
      int          ntok;
      int          groups;
      int          cnt;
      set_length(len);
      left = len;
      groups = 0;
      while (left != 0 && !(abort_groups != 0 && groups == abort_groups)) begin
         // unused flag bits past the end of the stream stay random
         flags = 8'($urandom);
         ntok = 0;
         while (ntok < 8 && left != 0) begin
            if (left < 3 || $urandom_range(0, 99) < lit_pct) begin
               flags[ntok] = 1'b1;
               tok_lo[ntok] = 8'($urandom);
               left = left - 32'd1;
            end else begin
               flags[ntok] = 1'b0;
               cnt = $urandom_range(3, (left < 18) ? int'(left) : 18);
               off = pick_offset();
               tok_lo[ntok] = off[7:0];
               tok_hi[ntok] = {off[11:8], 4'(cnt - 3)};
               left = left - 32'(cnt);
            end
            ntok++;
         end
         send_byte(flags);
         for (int i = 0; i < ntok; i++) begin
            send_byte(tok_lo[i]);
            if (!flags[i])
               send_byte(tok_hi[i]);
         end
         groups++;
      end
      if (left == 0)
         send_sum($urandom_range(0, 4) == 0);
   endtask

   // ------------------------------------------------------------------------
   // Tests
   // ------------------------------------------------------------------------

   // Length from reset: one literal, then a correct checksum
   task automatic test_default_length();
      send_byte(8'h01);
      send_byte(8'hFF);
      send_sum(1'b0);
   endtask

   // Longest match over a window never written: all blanks
   task automatic test_blank_window();
      set_length(32'd18);
      send_byte(8'h00);
      send_byte(8'h00);
      send_byte(8'h0F);
      send_sum(1'b0);
   endtask

   // Overlapping copy at offset 1, farthest offset, literals, bad checksum
   task automatic test_overlap_copy();
      set_length(32'd24);
      send_byte(8'h19);
      send_byte(8'h00);
      send_byte(8'h01);
      send_byte(8'h0F);
      send_byte(8'hFF);
      send_byte(8'hF0);
      send_byte(8'hA5);
      send_byte(8'h5A);
      send_sum(1'b1);
   endtask

   // Zero length: only checksum bytes against a sum of zero
   task automatic test_zero_length();
      set_length(32'd0);
      send_sum(1'b0);
      send_sum(1'b1);
   endtask

   // Random streams with random lengths, some cut short
   task automatic test_random_streams();
      int start;
      int r;
      logic [31:0] len;
      start = sent_count;
      while (sent_count - start < RANDOM_BYTES) begin
         r = $urandom_range(0, 99);
         if (r < 5)
            len = 32'd0;
         else if (r < 70)
            len = 32'($urandom_range(1, 24));
         else if (r < 90)
            len = 32'($urandom_range(25, 120));
         else
            len = 32'($urandom_range(1, 3));
         no_idle = ($urandom_range(0, 4) == 0);
         run_stream(len, $urandom_range(25, 75),
                    ($urandom_range(0, 9) == 0) ? $urandom_range(1, 2) : 0);
      end
      no_idle = 1'b0;
   endtask

   // Largest length: a stream that is abandoned by the next write
   task automatic test_full_length();
      run_stream(32'hFFFF_FFFF, 40, 3);
      run_stream(32'd1, 50, 0);
   endtask

   // Match longer than what is left: overrun, then every input is ignored
   task automatic test_overrun_halt();
      set_length(32'd5);
      send_byte(8'h00);
      send_byte(8'h10);
      send_byte(8'h0F);
      for (int i = 0; i < 3; i++)
         send_byte(8'($urandom));
      // a length write does not leave the halted state
      set_length(32'd1);
      send_byte(8'h01);
      send_byte(8'h42);
      send_sum(1'b0);
   endtask

   initial begin
      reset_decoder();
      repeat (8) @(negedge clock);
      reset <= 1'b0;

      test_default_length();
      test_blank_window();
      test_overlap_copy();
      test_zero_length();
      test_random_streams();
      test_full_length();
      test_overrun_halt();

      wait_idle();
      $display("Sent %0d compressed bytes; checked %0d decoded bytes,", sent_count, n_data);
      $display("%0d good and %0d bad sums and %0d overruns; lengths 0, 1, 18 and 2^32-1.",
               n_ok, n_bad, n_overrun);
      if (fail_count == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end

endmodule
